// ===== rtl/rc4_stream_cipher_assert.svh =====
// Assertion macros of the RC4 stream cipher, used by the sequencer.
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RC4_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RC4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rc4_pkg.sv =====
// Package with shared constants and types of the RC4 stream cipher.
`timescale 1ns / 1ps
package rc4_pkg;

    localparam int TABLE_SIZE      = 256;
    localparam int ADDR_W          = 8;
    localparam int BYTE_W          = 8;
    localparam int KEY_CNT_W       = 9;
    localparam int DEF_MAX_KEY_LEN = 256;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

// ===== rtl/rc4_stream_cipher.sv =====
// RC4 stream cipher top level with memories, sequencer and output register.
//
// The block takes one item at a time. A key byte without tlast is taken and the
// block stays idle. The key byte marked by tlast also starts the key schedule:
// an identity fill of the permutation memory, then 256 swap steps that each read
// S[i] and the key byte, read S[j], write S[i] and write S[j]. A data byte makes
// three dependent reads and two writes, sharing the single read and single write
// port of the permutation memory, then the XOR and a push that waits for a
// free output register; a data byte before any key goes straight to the push
// and leaves unchanged with the keyed flag low. Results wait in an output
// register, and the next item is taken while one waits there.
`timescale 1ns / 1ps
module rc4_stream_cipher #(
    parameter int MAX_KEY_LEN = rc4_pkg::DEF_MAX_KEY_LEN
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [rc4_pkg::BYTE_W-1:0] s_axis_tdata,  // [7:0] byte_in
    input  logic                       s_axis_tlast,
    input  logic                       s_axis_tuser,  // [0] cmd
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [rc4_pkg::BYTE_W-1:0] m_axis_tdata,  // [7:0] out_byte
    output logic                       m_axis_tuser   // [0] keyed
);
    import rc4_pkg::*;

    t_ram_req          perm_req;
    t_ram_req          key_req;
    logic [BYTE_W-1:0] perm_rdata;
    logic [BYTE_W-1:0] key_rdata;
    logic              out_free;
    logic              res_valid;
    logic [BYTE_W-1:0] res_byte;
    logic              res_keyed;

    logic              r_m_valid;
    logic [BYTE_W-1:0] r_m_data;
    logic              r_m_keyed;

    assign out_free = !r_m_valid || m_axis_tready;

    rc4_ram u_perm_ram (
        .i_clk   (i_clk),
        .i_req   (perm_req),
        .o_rdata (perm_rdata)
    );

    rc4_ram u_key_ram (
        .i_clk   (i_clk),
        .i_req   (key_req),
        .o_rdata (key_rdata)
    );

    rc4_seq #(
        .MAX_KEY_LEN (MAX_KEY_LEN)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (s_axis_tuser),
        .i_byte       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_out_free   (out_free),
        .o_res_valid  (res_valid),
        .o_res_byte   (res_byte),
        .o_res_keyed  (res_keyed),
        .o_perm_req   (perm_req),
        .i_perm_rdata (perm_rdata),
        .o_key_req    (key_req),
        .i_key_rdata  (key_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_m_data  <= res_byte;
            r_m_keyed <= res_keyed;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_keyed;

endmodule

// ===== rtl/rc4_ram.sv =====
// Single write port, single registered read port byte memory.
`timescale 1ns / 1ps
module rc4_ram (
    input  logic                    i_clk,
    input  rc4_pkg::t_ram_req       i_req,
    output logic [rc4_pkg::BYTE_W-1:0] o_rdata
);
    import rc4_pkg::*;

    logic [BYTE_W-1:0] r_mem [TABLE_SIZE];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rc4_seq.sv =====
// Sequencer of the RC4 cipher with the shared pointer adder.
`timescale 1ns / 1ps
module rc4_seq #(
    parameter int MAX_KEY_LEN = rc4_pkg::DEF_MAX_KEY_LEN
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_cmd,
    input  logic [rc4_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_last,
    input  logic                       i_out_free,
    output logic                       o_res_valid,
    output logic [rc4_pkg::BYTE_W-1:0] o_res_byte,
    output logic                       o_res_keyed,
    output rc4_pkg::t_ram_req          o_perm_req,
    input  logic [rc4_pkg::BYTE_W-1:0] i_perm_rdata,
    output rc4_pkg::t_ram_req          o_key_req,
    input  logic [rc4_pkg::BYTE_W-1:0] i_key_rdata
);
    import rc4_pkg::*;

    `include "rc4_stream_cipher_assert.svh"

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FILL   = 4'd1;
    localparam logic [3:0] S_K_RD_I = 4'd2;
    localparam logic [3:0] S_K_RD_J = 4'd3;
    localparam logic [3:0] S_K_WR_I = 4'd4;
    localparam logic [3:0] S_K_WR_J = 4'd5;
    localparam logic [3:0] S_D_RD_I = 4'd6;
    localparam logic [3:0] S_D_RD_J = 4'd7;
    localparam logic [3:0] S_D_WR_I = 4'd8;
    localparam logic [3:0] S_D_WR_J = 4'd9;
    localparam logic [3:0] S_D_RD_T = 4'd10;
    localparam logic [3:0] S_D_XOR  = 4'd11;
    localparam logic [3:0] S_D_OUT  = 4'd12;

    localparam logic [KEY_CNT_W-1:0] KeyLimit = KEY_CNT_W'(MAX_KEY_LEN);
    localparam logic [ADDR_W-1:0]    LastIdx  = ADDR_W'(TABLE_SIZE - 1);

    logic [3:0]           r_state, n_state;
    logic [ADDR_W-1:0]    r_i, n_i;
    logic [ADDR_W-1:0]    r_j, n_j;
    logic [ADDR_W-1:0]    r_n, n_n;
    logic [ADDR_W-1:0]    r_kidx, n_kidx;
    logic [BYTE_W-1:0]    r_si, n_si;
    logic [BYTE_W-1:0]    r_sj, n_sj;
    logic [BYTE_W-1:0]    r_byte, n_byte;
    logic [KEY_CNT_W-1:0] r_key_count, n_key_count;
    logic                 r_keyed, n_keyed;

    logic [BYTE_W-1:0]    add_a, add_b, add_c, add_sum;
    logic [BYTE_W-1:0]    key_byte;
    logic [KEY_CNT_W-1:0] kidx_inc;
    logic                 accept;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign key_byte = (r_key_count != '0) ? i_key_rdata : '0;
    assign kidx_inc = {1'b0, r_kidx} + KEY_CNT_W'(1);

    always_comb begin
        add_a = r_n;
        add_b = BYTE_W'(1);
        add_c = '0;
        unique case (r_state)
            S_IDLE: begin
                add_a = r_i;
            end
            S_K_RD_J: begin
                add_a = r_j;
                add_b = i_perm_rdata;
                add_c = key_byte;
            end
            S_D_RD_J: begin
                add_a = r_j;
                add_b = i_perm_rdata;
            end
            S_D_RD_T: begin
                add_a = r_si;
                add_b = r_sj;
            end
            default: begin
                add_a = r_n;
            end
        endcase
        add_sum = add_a + add_b + add_c;
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_n         = r_n;
        n_kidx      = r_kidx;
        n_si        = r_si;
        n_sj        = r_sj;
        n_byte      = r_byte;
        n_key_count = r_key_count;
        n_keyed     = r_keyed;
        o_perm_req  = '0;
        o_key_req   = '0;
        o_res_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_byte = i_byte;
                    if (i_cmd == CMD_KEY) begin
                        if (r_key_count < KeyLimit) begin
                            o_key_req.we    = 1'b1;
                            o_key_req.waddr = r_key_count[ADDR_W-1:0];
                            o_key_req.wdata = i_byte;
                            n_key_count     = r_key_count + KEY_CNT_W'(1);
                        end
                        if (i_last) begin
                            n_n     = '0;
                            n_state = S_FILL;
                        end
                    end else if (r_keyed) begin
                        n_i     = add_sum;
                        n_state = S_D_RD_I;
                    end else begin
                        n_state = S_D_OUT;
                    end
                end
            end
            S_FILL: begin
                o_perm_req.we    = 1'b1;
                o_perm_req.waddr = r_n;
                o_perm_req.wdata = r_n;
                n_n              = add_sum;
                if (r_n == LastIdx) begin
                    n_j     = '0;
                    n_kidx  = '0;
                    n_state = S_K_RD_I;
                end
            end
            S_K_RD_I: begin
                o_perm_req.raddr = r_n;
                o_key_req.raddr  = r_kidx;
                n_state          = S_K_RD_J;
            end
            S_K_RD_J: begin
                n_si             = i_perm_rdata;
                n_j              = add_sum;
                o_perm_req.raddr = add_sum;
                n_kidx           = (kidx_inc == r_key_count) ? '0 : kidx_inc[ADDR_W-1:0];
                n_state          = S_K_WR_I;
            end
            S_K_WR_I: begin
                o_perm_req.we    = 1'b1;
                o_perm_req.waddr = r_n;
                o_perm_req.wdata = i_perm_rdata;
                n_state          = S_K_WR_J;
            end
            S_K_WR_J: begin
                o_perm_req.we    = 1'b1;
                o_perm_req.waddr = r_j;
                o_perm_req.wdata = r_si;
                n_n              = add_sum;
                if (r_n == LastIdx) begin
                    n_i         = '0;
                    n_j         = '0;
                    n_key_count = '0;
                    n_keyed     = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_K_RD_I;
                end
            end
            S_D_RD_I: begin
                o_perm_req.raddr = r_i;
                n_state          = S_D_RD_J;
            end
            S_D_RD_J: begin
                n_si             = i_perm_rdata;
                n_j              = add_sum;
                o_perm_req.raddr = add_sum;
                n_state          = S_D_WR_I;
            end
            S_D_WR_I: begin
                n_sj             = i_perm_rdata;
                o_perm_req.we    = 1'b1;
                o_perm_req.waddr = r_i;
                o_perm_req.wdata = i_perm_rdata;
                n_state          = S_D_WR_J;
            end
            S_D_WR_J: begin
                o_perm_req.we    = 1'b1;
                o_perm_req.waddr = r_j;
                o_perm_req.wdata = r_si;
                n_state          = S_D_RD_T;
            end
            S_D_RD_T: begin
                o_perm_req.raddr = add_sum;
                n_state          = S_D_XOR;
            end
            S_D_XOR: begin
                n_byte  = r_byte ^ i_perm_rdata;
                n_state = S_D_OUT;
            end
            S_D_OUT: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res_byte  = r_byte;
    assign o_res_keyed = r_keyed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_key_count <= '0;
            r_keyed     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_key_count <= n_key_count;
            r_keyed     <= n_keyed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_kidx <= n_kidx;
        r_si   <= n_si;
        r_sj   <= n_sj;
        r_byte <= n_byte;
    end

    `RC4_ASSERT_SAME(a_push_free, i_clk, i_rst_n, o_res_valid, i_out_free,
        "result pushed into a full output register")
    `RC4_ASSERT_NEXT(a_fill_done, i_clk, i_rst_n, (r_state == S_FILL) && (r_n == LastIdx),
        r_state == S_K_RD_I, "identity fill did not hand over to the schedule")
    `RC4_ASSERT_NEXT(a_keyed_sticky, i_clk, i_rst_n, r_keyed, r_keyed,
        "keyed flag dropped without reset")
    `RC4_ASSERT_SAME(a_key_count_cap, i_clk, i_rst_n, 1'b1, r_key_count <= KeyLimit,
        "key count exceeds the maximum key length")

endmodule

// ===== sim/rc4_stream_cipher_checker.sv =====
// Checker that predicts and compares the result items of the RC4 stream cipher.
`timescale 1ns / 1ps
module rc4_stream_cipher_checker #(
    parameter int MAX_KEY_LEN = rc4_pkg::DEF_MAX_KEY_LEN
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [rc4_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                       i_in_last,
    input  logic                       i_in_cmd,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [rc4_pkg::BYTE_W-1:0] i_out_byte,
    input  logic                       i_out_keyed,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_results_seen,
    output int                         o_schedules_run
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       keyed;
    } t_cipher_result;

    t_cipher_result expected_bytes[$];

    logic [7:0] perm[rc4_pkg::TABLE_SIZE];
    logic [7:0] key_bytes[rc4_pkg::TABLE_SIZE];
    logic [7:0] idx_i;
    logic [7:0] idx_j;
    int         key_len;
    logic       keyed;
    int         fail_total;
    int         results_seen;
    int         schedules_run;

    assign o_fail_count    = fail_total;
    assign o_pending       = expected_bytes.size();
    assign o_results_seen  = results_seen;
    assign o_schedules_run = schedules_run;

    initial begin
        fail_total    = 0;
        results_seen  = 0;
        schedules_run = 0;
        key_len       = 0;
        keyed         = 1'b0;
        idx_i         = 8'd0;
        idx_j         = 8'd0;
    end

    task automatic run_key_schedule();
        int         len;
        int         n;
        logic [7:0] acc;
        logic [7:0] kb;
        logic [7:0] t;
        len = (key_len > rc4_pkg::TABLE_SIZE) ? rc4_pkg::TABLE_SIZE : key_len;
        for (n = 0; n < rc4_pkg::TABLE_SIZE; n++) begin
            perm[n] = n[7:0];
        end
        acc = 8'd0;
        for (n = 0; n < rc4_pkg::TABLE_SIZE; n++) begin
            kb      = (len != 0) ? key_bytes[n % len] : 8'd0;
            acc     = acc + perm[n] + kb;
            t       = perm[n];
            perm[n] = perm[acc];
            perm[acc] = t;
        end
        idx_i   = 8'd0;
        idx_j   = 8'd0;
        key_len = 0;
        keyed   = 1'b1;
        schedules_run++;
    endtask

    task automatic absorb_key_byte(input logic [7:0] b, input logic last);
        if (key_len < MAX_KEY_LEN && key_len < rc4_pkg::TABLE_SIZE) begin
            key_bytes[key_len] = b;
            key_len++;
        end
        if (last) begin
            run_key_schedule();
        end
    endtask

    function automatic t_cipher_result encrypt_byte(input logic [7:0] b);
        t_cipher_result r;
        logic [7:0]     t;
        logic [7:0]     sum;
        if (!keyed) begin
            r.out_byte = b;
            r.keyed    = 1'b0;
        end else begin
            idx_i       = idx_i + 8'd1;
            idx_j       = idx_j + perm[idx_i];
            t           = perm[idx_i];
            perm[idx_i] = perm[idx_j];
            perm[idx_j] = t;
            sum         = perm[idx_i] + perm[idx_j];
            r.out_byte  = b ^ perm[sum];
            r.keyed     = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_cipher_result exp_r;
        if (!i_rst_n) begin
            expected_bytes.delete();
            idx_i   = 8'd0;
            idx_j   = 8'd0;
            key_len = 0;
            keyed   = 1'b0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected result, expected none, actual byte %02h keyed %0b",
                             $time, i_out_byte, i_out_keyed);
                end else begin
                    exp_r = expected_bytes.pop_front();
                    results_seen++;
                    if (exp_r.out_byte !== i_out_byte) begin
                        fail_total++;
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                                 $time, exp_r.out_byte, i_out_byte);
                    end
                    if (exp_r.keyed !== i_out_keyed) begin
                        fail_total++;
                        $display("%0t: keyed mismatch, expected %0b, actual %0b",
                                 $time, exp_r.keyed, i_out_keyed);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_cmd == rc4_pkg::CMD_KEY) begin
                    absorb_key_byte(i_in_byte, i_in_last);
                end else begin
                    expected_bytes.push_back(encrypt_byte(i_in_byte));
                end
            end
        end
    end

endmodule

// ===== sim/tb_rc4_stream_cipher.sv =====
// Testbench top that drives key and data items into the RC4 stream cipher.
`timescale 1ns / 1ps
module tb_rc4_stream_cipher;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'd0;
    logic       s_axis_tlast  = 1'b0;
    logic       s_axis_tuser  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tuser;

    int fail_count;
    int pending;
    int results_seen;
    int schedules_run;
    int items_sent    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_trigger  = 0;
    int cycle_count   = 0;

    rc4_stream_cipher u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    rc4_stream_cipher_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .i_in_ready     (s_axis_tready),
        .i_in_byte      (s_axis_tdata),
        .i_in_last      (s_axis_tlast),
        .i_in_cmd       (s_axis_tuser),
        .i_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .i_out_byte     (m_axis_tdata),
        .i_out_keyed    (m_axis_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen),
        .o_schedules_run(schedules_run)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending", cycle_count, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_trigger != hold_seen) begin
                hold_seen = hold_trigger;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    task automatic send_key(input int len);
        int n;
        for (n = 0; n < len; n++) begin
            send_item(rc4_pkg::CMD_KEY, 8'($urandom_range(0, 255)), n == len - 1);
        end
    endtask

    task automatic send_data_burst(input int len);
        int n;
        for (n = 0; n < len; n++) begin
            send_item(rc4_pkg::CMD_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_session();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            // An unfinished key must not disturb the keystream of the current key.
            for (n = $urandom_range(1, 4); n > 0; n--) begin
                send_item(rc4_pkg::CMD_KEY, 8'($urandom_range(0, 255)), 1'b0);
            end
            send_data_burst($urandom_range(2, 8));
        end
        send_key((kind < 80) ? $urandom_range(1, 16) : $urandom_range(17, 48));
        send_data_burst($urandom_range(4, 40));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 80;

        send_item(rc4_pkg::CMD_DATA, 8'h00, 1'b0);
        send_item(rc4_pkg::CMD_DATA, 8'hFF, 1'b0);
        send_item(rc4_pkg::CMD_DATA, 8'hA5, 1'b1);
        send_item(rc4_pkg::CMD_KEY, 8'hFF, 1'b1);
        send_item(rc4_pkg::CMD_DATA, 8'h00, 1'b0);
        send_item(rc4_pkg::CMD_DATA, 8'hFF, 1'b0);
        send_item(rc4_pkg::CMD_KEY, 8'h00, 1'b0);
        send_item(rc4_pkg::CMD_KEY, 8'h80, 1'b0);
        send_item(rc4_pkg::CMD_KEY, 8'h7F, 1'b1);
        send_item(rc4_pkg::CMD_DATA, 8'h01, 1'b0);
        send_item(rc4_pkg::CMD_DATA, 8'h80, 1'b0);
        send_item(rc4_pkg::CMD_DATA, 8'hFE, 1'b0);
        send_item(rc4_pkg::CMD_DATA, 8'h55, 1'b0);
        send_item(rc4_pkg::CMD_KEY, 8'h01, 1'b0);
        send_item(rc4_pkg::CMD_KEY, 8'h02, 1'b0);
        send_item(rc4_pkg::CMD_DATA, 8'h00, 1'b1);
        send_item(rc4_pkg::CMD_DATA, 8'hFF, 1'b1);
        send_item(rc4_pkg::CMD_KEY, 8'h03, 1'b1);
        send_item(rc4_pkg::CMD_DATA, 8'h3C, 1'b0);
        send_item(rc4_pkg::CMD_DATA, 8'hC3, 1'b0);

        send_key(rc4_pkg::TABLE_SIZE);
        send_data_burst(30);
        while (items_sent < 420) begin
            run_session();
        end
        wait_drained();

        send_idle_pct = 80;
        recv_idle_pct = 29;
        while (items_sent < 660) begin
            run_session();
        end
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // The final key byte lies past the longest key and is dropped,
        // yet it still starts the schedule.
        send_key(rc4_pkg::TABLE_SIZE + 1);
        send_data_burst(10);
        hold_trigger++;
        send_data_burst(40);
        while (items_sent < 1150) begin
            run_session();
        end
        send_data_burst(8);

        wait_drained();
        repeat (1300) @(posedge i_clk);

        $display("Sent %0d items under three idle patterns and a long output stall.", items_sent);
        $display("Checked %0d results over %0d key schedules, overlong keys included.",
                 results_seen, schedules_run);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== rc4_stream_cipher.f =====
+incdir+rtl
rtl/rc4_pkg.sv
rtl/rc4_ram.sv
rtl/rc4_seq.sv
rtl/rc4_stream_cipher.sv
sim/rc4_stream_cipher_checker.sv
sim/tb_rc4_stream_cipher.sv
